// ----- src/ggb_pkg.sv -----
`default_nettype none
package ggb_pkg;
  localparam int MaxVertices = 128;
  localparam int VW = $clog2(MaxVertices);
  localparam int CW = VW + 1;

  localparam logic CfgVertexCount   = 1'b0;
  localparam logic CfgRequiredGirth = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_SCAN_RD, ST_SCAN_CHK, ST_LOAD_WAIT,
    ST_POP_RD, ST_POP, ST_NB, ST_EDGE_DONE, ST_DONE
  } ggb_state_t;

  typedef struct packed {
    logic load_edge;
    logic clr_start;
    logic scan_rd;
    logic scan_next_v;
    logic bfs_init;
    logic pop_rd;
    logic pop_take;
    logic nb_step;
    logic edge_done;
    logic best_clear;
    logic emit;
  } ggb_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic load_done;
    logic scan_end;
    logic scan_hit;
    logic scan_self;
    logic queue_empty;
    logic row_end;
    logic found;
    logic stop_now;
  } ggb_sts_t;
endpackage
`default_nettype wire

// ----- src/graph_girth_bound_bfs.sv -----
`default_nettype none
// Girth bound by one breadth-first search per stored edge that is not a
// self-loop. After reset the block runs a clearing pass over every row with
// busy high. Each start with busy low takes one edge and then holds busy
// while both adjacency rows are updated through the row memory. An edge with
// last set waits for its own rows, then scans each vertex pair (u <= v, both
// below the vertex count); a self-loop counts as a cycle of length one, and
// any other stored edge costs a search over the dequeued vertices and their
// rows. The result is shown for exactly one cycle on out_valid; the
// receiver cannot stall it. That cycle opens a clearing pass that empties
// the adjacency memory before the next edge is taken.
module graph_girth_bound_bfs (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [6:0] in_edge_u,
  input  wire logic [6:0] in_edge_v,
  input  wire logic       in_last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output logic            out_valid,
  output logic [7:0]      out_girth_bound,
  output logic            out_no_cycle
);
  import ggb_pkg::*;

  ggb_cmd_t cmd;
  ggb_sts_t sts;
  logic     ctrl_busy;
  logic [2:0] hold_r;
  logic     cfg_wr;

  // keep busy while an edge load is in flight
  always_ff @(posedge clk) begin
    if (!rst_n) hold_r <= '0;
    else if (start && !busy) hold_r <= 3'd4;
    else if (hold_r != '0) hold_r <= hold_r - 3'd1;
  end
  assign busy = ctrl_busy || (hold_r != '0);
  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid && (cfg_index < 8'd2);

  ggb_ctrl u_ctrl (
    .clk, .rst_n, .start(start && !busy), .in_last, .sts, .busy(ctrl_busy), .cmd
  );

  ggb_dp u_dp (
    .clk, .rst_n, .cmd, .in_edge_u, .in_edge_v,
    .cfg_valid(cfg_wr), .cfg_index(cfg_index[0:0]), .cfg_data,
    .sts, .out_valid, .out_girth_bound, .out_no_cycle
  );

  // result only while busy, never while idle
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> busy)
    else $error("result while idle");
  // a result says either a cycle or none
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_no_cycle == (out_girth_bound == 8'd0)))
    else $error("result flags disagree");
  // a new edge is never taken in the cycle after one was taken
  assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
    else $error("edge load overlap");
endmodule
`default_nettype wire

// ----- src/ggb_ram.sv -----
`default_nettype none
module ggb_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/ggb_ctrl.sv -----
`default_nettype none
module ggb_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            in_last,
  input  wire ggb_pkg::ggb_sts_t sts,
  output logic                 busy,
  output ggb_pkg::ggb_cmd_t    cmd
);
  import ggb_pkg::*;

  ggb_state_t state_r, state_nxt;

  // state register, a clearing pass follows reset
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load_edge = 1'b1;
          if (in_last) begin
            cmd.best_clear = 1'b1;
            state_nxt = ST_LOAD_WAIT;
          end
        end
      end
      ST_LOAD_WAIT: begin
        if (sts.load_done) state_nxt = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (sts.scan_end) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (!sts.scan_hit) begin
          cmd.scan_next_v = 1'b1;
          state_nxt = ST_SCAN_RD;
        end else if (sts.scan_self) begin
          cmd.edge_done = 1'b1;
          state_nxt = ST_EDGE_DONE;
        end else begin
          cmd.bfs_init = 1'b1;
          state_nxt = ST_POP_RD;
        end
      end
      ST_POP_RD: begin
        if (sts.queue_empty) begin
          state_nxt = ST_EDGE_DONE;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        cmd.pop_take = 1'b1;
        state_nxt = ST_NB;
      end
      ST_NB: begin
        cmd.nb_step = 1'b1;
        if (sts.found) begin
          cmd.edge_done = 1'b1;
          state_nxt = ST_EDGE_DONE;
        end else if (sts.row_end) begin
          state_nxt = ST_POP_RD;
        end
      end
      ST_EDGE_DONE: begin
        if (sts.stop_now) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.scan_next_v = 1'b1;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_DONE: begin
        cmd.emit = 1'b1;
        cmd.clr_start = 1'b1;
        state_nxt = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- src/ggb_dp.sv -----
`default_nettype none
module ggb_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ggb_pkg::ggb_cmd_t   cmd,
  input  wire logic [6:0]          in_edge_u,
  input  wire logic [6:0]          in_edge_v,
  input  wire logic                cfg_valid,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [7:0]          cfg_data,
  output ggb_pkg::ggb_sts_t        sts,
  output logic                     out_valid,
  output logic [7:0]               out_girth_bound,
  output logic                     out_no_cycle
);
  import ggb_pkg::*;

  logic [7:0] vcount_r, rgirth_r;
  logic [VW:0] n_lim;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 8'd128;
      rgirth_r <= 8'd0;
    end else if (cfg_valid) begin
      if (cfg_index == CfgVertexCount) vcount_r <= cfg_data;
      else                             rgirth_r <= cfg_data;
    end
  end

  assign n_lim = ({1'b0, vcount_r} > 9'(MaxVertices)) ? CW'(MaxVertices) : CW'(vcount_r);

  // adjacency rows in memory, one row per vertex
  logic [VW-1:0] clr_cnt_r;
  logic          clr_act_r;
  logic [MaxVertices-1:0] row_q;
  logic [MaxVertices-1:0] adj_wd, adj_wd2;
  logic [VW-1:0] adj_wa, adj_wa2, adj_ra;
  logic          adj_we, adj_we2;
  logic          ld_second_r;
  logic [VW-1:0] ld_u_r, ld_v_r;

  // load: each edge sets a bit in row u and row v; each row is read, then written back
  logic [1:0]    ld_phase_r;

  // scan and bfs registers
  logic [CW-1:0] su_r, sv_r;
  logic [VW-1:0] now_r;
  logic [CW-1:0] w_r;
  logic [7:0]    dnow_r;
  logic [7:0]    dnow;
  logic [MaxVertices-1:0] seen_r;
  logic [CW-1:0] head_r, tail_r;
  logic [7:0]    best_r;
  logic          best_ok_r;
  logic [VW-1:0] q_wa, q_ra;
  logic          q_we;
  logic [VW-1:0] q_wd, q_rd;
  logic [VW-1:0] d_wa, d_ra;
  logic          d_we;
  logic [7:0]    d_wd, d_rd;

  // single-port-ish usage: write ports chosen by phase
  always_comb begin
    adj_we = 1'b0; adj_wa = '0; adj_wd = '0;
    adj_we2 = 1'b0; adj_wa2 = '0; adj_wd2 = '0;
    if (clr_act_r) begin
      adj_we = 1'b1; adj_wa = clr_cnt_r; adj_wd = '0;
    end else if (ld_phase_r == 2'd1) begin
      adj_we = 1'b1; adj_wa = ld_u_r; adj_wd = row_q | (MaxVertices'(1) << ld_v_r);
    end else if (ld_phase_r == 2'd3) begin
      adj_we = 1'b1; adj_wa = ld_v_r; adj_wd = row_q | (MaxVertices'(1) << ld_u_r);
    end
    adj_we2 = adj_we; adj_wa2 = adj_wa; adj_wd2 = adj_wd;
  end

  // row address goes straight to the memory on a scan read or a pop
  logic [VW-1:0] rd_addr_r;
  assign adj_ra = cmd.scan_rd ? su_i : (cmd.pop_take ? q_rd : rd_addr_r);

  ggb_ram #(.Width(MaxVertices), .Depth(MaxVertices)) u_adj (
    .clk, .we(adj_we2), .waddr(adj_wa2), .wdata(adj_wd2), .raddr(adj_ra), .rdata(row_q)
  );
  ggb_ram #(.Width(VW), .Depth(MaxVertices)) u_queue (
    .clk, .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd)
  );
  ggb_ram #(.Width(8), .Depth(MaxVertices)) u_dist (
    .clk, .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd)
  );

  // the row of the vertex being expanded stays on row_q for the whole sweep
  logic w_ok, w_edge, w_banned, w_new;
  logic [VW-1:0] w_i;
  logic [VW-1:0] su_i, sv_i;
  assign w_i = w_r[VW-1:0];
  assign su_i = su_r[VW-1:0];
  assign sv_i = sv_r[VW-1:0];
  assign w_ok = w_r < n_lim;
  assign w_edge = w_ok && row_q[w_i];
  assign w_banned = (now_r == su_i && w_i == sv_i) || (now_r == sv_i && w_i == su_i);
  assign w_new = w_edge && !w_banned && !seen_r[w_i];

  // distance of the vertex being expanded arrives in the first sweep cycle
  assign dnow = (w_r == '0) ? d_rd : dnow_r;

  // queue and distance writes happen in bfs_init and on each new neighbour
  always_comb begin
    q_we = 1'b0; q_wa = tail_r[VW-1:0]; q_wd = w_i;
    d_we = 1'b0; d_wa = w_i; d_wd = dnow + 8'd1;
    if (cmd.bfs_init) begin
      q_we = 1'b1; q_wa = '0; q_wd = su_i;
      d_we = 1'b1; d_wa = su_i; d_wd = '0;
    end else if (cmd.nb_step && w_new) begin
      q_we = tail_r < CW'(MaxVertices);
      d_we = 1'b1;
    end
  end
  assign q_ra = head_r[VW-1:0];
  assign d_ra = q_rd;

  // candidate length when the target is reached
  logic [8:0] cand;
  assign cand = {1'b0, dnow} + 9'd2;

  // sequencing of loads, scan, bfs and clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r <= 1'b1;
      clr_cnt_r <= '0;
      ld_phase_r <= '0;
      ld_second_r <= 1'b0;
      out_valid <= 1'b0;
      best_ok_r <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
      // edge load: phase 0 idle, 1 write u, 2 read v, 3 write v
      if (cmd.load_edge) begin
        ld_u_r <= in_edge_u; ld_v_r <= in_edge_v;
        rd_addr_r <= in_edge_u;
        ld_phase_r <= 2'd0;
        ld_second_r <= 1'b1;
      end
      if (ld_second_r) begin
        ld_second_r <= 1'b0;
        ld_phase_r <= 2'd1;
      end else if (ld_phase_r == 2'd1) begin
        rd_addr_r <= ld_v_r;
        ld_phase_r <= 2'd2;
      end else if (ld_phase_r == 2'd2) begin
        ld_phase_r <= 2'd3;
      end else if (ld_phase_r == 2'd3) begin
        ld_phase_r <= 2'd0;
      end
      if (cmd.best_clear) begin
        best_ok_r <= 1'b0;
        best_r <= '0;
        su_r <= '0; sv_r <= '0;
      end
      if (cmd.scan_rd) rd_addr_r <= su_i;
      if (cmd.scan_next_v) begin
        if (sv_r + CW'(1) >= n_lim) begin
          su_r <= su_r + CW'(1); sv_r <= su_r + CW'(1);
        end else sv_r <= sv_r + CW'(1);
      end
      if (cmd.bfs_init) begin
        seen_r <= MaxVertices'(1) << su_i;
        head_r <= '0; tail_r <= CW'(1);
      end
      if (cmd.pop_rd) head_r <= head_r + CW'(1);
      if (cmd.pop_take) begin
        now_r <= q_rd; rd_addr_r <= q_rd; w_r <= '0;
      end
      if (cmd.nb_step) begin
        if (w_r == '0) dnow_r <= d_rd;
        w_r <= w_r + CW'(1);
        if (w_new) begin
          seen_r[w_i] <= 1'b1;
          if (tail_r < CW'(MaxVertices)) tail_r <= tail_r + CW'(1);
        end
      end
      if (cmd.edge_done) begin
        if (sts.scan_self) begin
          if (!best_ok_r || 8'd1 < best_r) begin best_r <= 8'd1; best_ok_r <= 1'b1; end
        end else if (!best_ok_r || cand[7:0] < best_r) begin
          best_r <= cand[7:0]; best_ok_r <= 1'b1;
        end
      end
      if (cmd.clr_start) begin
        clr_act_r <= 1'b1; clr_cnt_r <= '0;
      end else if (clr_act_r) begin
        clr_cnt_r <= clr_cnt_r + VW'(1);
        if (clr_cnt_r == VW'(MaxVertices - 1)) clr_act_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.clr_last = clr_cnt_r == VW'(MaxVertices - 1);
    sts.load_done = (ld_phase_r == 2'd0) && !ld_second_r;
    sts.scan_end = su_r >= n_lim;
    sts.scan_hit = row_q[sv_i];
    sts.scan_self = su_r == sv_r;
    sts.queue_empty = head_r >= tail_r;
    sts.row_end = w_r + CW'(1) >= n_lim;
    sts.found = w_new && w_i == sv_i;
    sts.stop_now = best_ok_r && ({1'b0, best_r} < {1'b0, rgirth_r});
  end

  assign out_girth_bound = best_ok_r ? best_r : 8'd0;
  assign out_no_cycle = !best_ok_r;
endmodule
`default_nettype wire
